// File: rtl/core/pbra_pkg.sv
`default_nettype none
package pbra_pkg;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_NOSPC  = 2'd1,
		ST_ZERO   = 2'd2
	} status_t;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	// Classified command handed from front to back.
	typedef struct packed {
		logic        is_free;
		logic        zero;
		logic [26:0] cnt;
		logic [26:0] addr_page;
		logic [26:0] align_pages;
	} cmd_t;

endpackage
`default_nettype wire

// File: rtl/core/page_bitmap_run_allocator.sv
`default_nettype none
// Next-fit allocator of contiguous page runs over a one-bit-per-page map
// kept in an on-chip memory. After reset a clearing pass rebuilds the map
// (the back sequencer takes no commands then). A front stage rounds alloc
// sizes up and free sizes down to pages and queues up to two requests; the
// back sequencer walks the map page by page: an alloc aligns a start per
// search pass, reads and checks each page examined, then marks the run
// page by page; a free clears page by page; both end in the result handshake.
module page_bitmap_run_allocator #(
	parameter int MAX_PAGES      = 16384,
	parameter int PAGE_BITS      = 12,
	parameter int RESERVED_PAGES = 4096
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire  [14:0] cfg_wdata,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire         req_type,
	input  wire  [26:0] size_bytes,
	input  wire  [26:0] align_bytes,
	input  wire  [25:0] free_addr,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [1:0]  status,
	output logic [25:0] run_addr
);

	logic [14:0]      usable_q;
	logic             cmd_valid, cmd_stall;
	pbra_pkg::cmd_t   cmd;

	// Limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			usable_q <= 15'd16384;
		else if (cfg_we)
			usable_q <= cfg_wdata;
	end

	pbra_front #(.PAGE_BITS(PAGE_BITS)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .req_type, .size_bytes,
		.align_bytes, .free_addr, .cmd_valid, .cmd_stall, .cmd
	);

	pbra_back #(.MAX_PAGES(MAX_PAGES), .PAGE_BITS(PAGE_BITS),
		.RESERVED_PAGES(RESERVED_PAGES)) u_back (
		.clk, .arst_n, .usable_pages(usable_q), .cmd_valid, .cmd_stall, .cmd,
		.out_valid, .out_stall, .status, .run_addr
	);

endmodule
`default_nettype wire

// File: rtl/core/pbra_front.sv
`default_nettype none
module pbra_front #(
	parameter int PAGE_BITS = 12
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_stall,
	input  wire               req_type,
	input  wire  [26:0]       size_bytes,
	input  wire  [26:0]       align_bytes,
	input  wire  [25:0]       free_addr,
	output logic              cmd_valid,
	input  wire               cmd_stall,
	output pbra_pkg::cmd_t    cmd
);

	localparam int DEPTH = 2;

	pbra_pkg::cmd_t   fifo_q [DEPTH];
	logic             wp_q, rp_q;
	logic [1:0]       cnt_q;
	pbra_pkg::cmd_t   c;
	logic [27:0]      up;
	logic [26:0]      ap;
	logic             push, pop;

	// Page count rounding and alignment reduced to a power of two.
	always_comb begin
		c = '0;
		c.is_free = (req_type == pbra_pkg::REQ_FREE);
		up = ({1'b0, size_bytes} + 28'((1 << PAGE_BITS) - 1)) >> PAGE_BITS;
		if (c.is_free)
			c.cnt = size_bytes >> PAGE_BITS;
		else
			c.cnt = up[26:0];
		c.zero = (c.cnt == '0);
		c.addr_page = 27'({1'b0, free_addr} >> PAGE_BITS);
		ap = align_bytes >> PAGE_BITS;
		c.align_pages = 27'd1;
		for (int i = 26; i >= 0; i--) begin
			if (ap[i] && c.align_pages == 27'd1)
				c.align_pages = 27'd1 << i;
		end
	end

	assign in_stall  = (cnt_q == 2'(DEPTH));
	assign push      = in_valid && !in_stall;
	assign cmd_valid = (cnt_q != 2'd0);
	assign pop       = cmd_valid && !cmd_stall;
	assign cmd       = fifo_q[rp_q];

	// Two-entry command queue.
	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wp_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (pop)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

`ifndef SYNTHESIS
	a_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'(DEPTH)) else $error("queue overflow");
	a_pop_ok: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != 2'd0) else $error("pop of empty queue");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 2'd1) else $error("count slip");
`endif

endmodule
`default_nettype wire

// File: rtl/core/pbra_back.sv
`default_nettype none
module pbra_back #(
	parameter int MAX_PAGES      = 16384,
	parameter int PAGE_BITS      = 12,
	parameter int RESERVED_PAGES = 4096
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire  [14:0]       usable_pages,
	input  wire               cmd_valid,
	output logic              cmd_stall,
	input  pbra_pkg::cmd_t    cmd,
	output logic              out_valid,
	input  wire               out_stall,
	output logic [1:0]        status,
	output logic [25:0]       run_addr
);

	localparam int AW = $clog2(MAX_PAGES);
	localparam int PW = AW + 1;
	localparam int IW = 32;
	localparam logic [AW-1:0] LAST_RST = (RESERVED_PAGES == 0) ?
		AW'(MAX_PAGES - 1) : AW'(RESERVED_PAGES - 1);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_RD, S_CHK, S_MARK, S_FREE, S_OUT
	} state_t;

	state_t          state_q;
	logic            mem_q [MAX_PAGES];
	logic            rdata_q;
	logic [AW-1:0]   last_q;
	logic [PW-1:0]   clr_q;
	logic [IW-1:0]   cand_q, p_q, stop_q, limit_q, lim2_q, a_q, cnt_q;
	logic            pass2_q, isfree_q;
	logic [1:0]      st_q;
	logic [25:0]     addr_q;
	logic [IW-1:0]   lim_c, lim2_c, nxt_c;
	logic            we;
	logic [AW-1:0]   waddr, raddr;
	logic            wdata;

	// Effective limits.
	always_comb begin
		lim_c = (IW'(usable_pages) > IW'(MAX_PAGES)) ? IW'(MAX_PAGES) : IW'(usable_pages);
		lim2_c = (IW'(last_q) > lim_c) ? lim_c : IW'(last_q);
		nxt_c = (p_q + 1 + a_q - 1) & ~(a_q - 1);
	end

	assign cmd_stall = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign status    = st_q;
	assign run_addr  = addr_q;

	// Page map write/read port.
	always_comb begin
		we = 1'b0; waddr = p_q[AW-1:0]; wdata = 1'b0;
		raddr = p_q[AW-1:0];
		case (state_q)
			S_CLEAR: begin
				we = 1'b1; waddr = clr_q[AW-1:0];
				wdata = (32'(clr_q) < 32'(RESERVED_PAGES));
			end
			S_MARK: begin we = 1'b1; wdata = 1'b1; end
			S_FREE: begin we = (p_q < stop_q); wdata = 1'b0; end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata_q <= mem_q[raddr];
	end

	// Sequencer: clear, search, mark, free, result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			last_q  <= LAST_RST;
			st_q    <= pbra_pkg::ST_OK;
			addr_q  <= '0;
			cand_q  <= '0; p_q <= '0; stop_q <= '0; limit_q <= '0;
			lim2_q  <= '0; a_q <= 32'd1; cnt_q <= '0;
			pass2_q <= 1'b0; isfree_q <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == MAX_PAGES - 1)
						state_q <= S_IDLE;
				end
				S_IDLE: if (cmd_valid) begin
					st_q   <= pbra_pkg::ST_OK;
					addr_q <= '0;
					cnt_q  <= 32'(cmd.cnt);
					a_q    <= 32'(cmd.align_pages);
					limit_q <= lim_c;
					lim2_q  <= lim2_c;
					pass2_q <= 1'b0;
					isfree_q <= cmd.is_free;
					if (cmd.zero) begin
						st_q <= pbra_pkg::ST_ZERO;
						state_q <= S_OUT;
					end else if (cmd.is_free) begin
						p_q <= 32'(cmd.addr_page);
						stop_q <= (32'(cmd.addr_page) + 32'(cmd.cnt) > 32'(MAX_PAGES)) ?
							32'(MAX_PAGES) : 32'(cmd.addr_page) + 32'(cmd.cnt);
						state_q <= S_FREE;
					end else begin
						// pass one starts just past the last run
						stop_q  <= '0;
						p_q     <= IW'(last_q) + 1;
						cand_q  <= IW'(last_q) + 1;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					// align the start candidate of this pass
					cand_q <= (cand_q + a_q - 1) & ~(a_q - 1);
					p_q    <= (cand_q + a_q - 1) & ~(a_q - 1);
					state_q <= S_CHK;
					stop_q <= 32'd1;
				end
				S_CHK: begin
					// stop_q==1: p_q address issued, no data yet
					if (stop_q == 32'd1) begin
						if ({1'b0, cand_q} + {1'b0, cnt_q} >
						    {1'b0, (pass2_q ? lim2_q : limit_q)}) begin
							if (!pass2_q) begin
								pass2_q <= 1'b1;
								cand_q <= '0;
								state_q <= S_RD;
							end else begin
								st_q <= pbra_pkg::ST_NOSPC;
								state_q <= S_OUT;
							end
						end else
							stop_q <= 32'd2;
					end else if (rdata_q) begin
						cand_q <= nxt_c; p_q <= nxt_c;
						stop_q <= 32'd1;
					end else if (p_q + 1 == cand_q + cnt_q) begin
						p_q <= cand_q;
						state_q <= S_MARK;
					end else begin
						// next page needs its own read cycle
						p_q <= p_q + 1;
						stop_q <= 32'd1;
					end
				end
				S_MARK: begin
					if (p_q + 1 == cand_q + cnt_q) begin
						last_q <= p_q[AW-1:0];
						addr_q <= 26'(cand_q << PAGE_BITS);
						state_q <= S_OUT;
					end
					p_q <= p_q + 1;
				end
				S_FREE: begin
					if (p_q + 1 >= stop_q)
						state_q <= S_OUT;
					p_q <= p_q + 1;
				end
				S_OUT: if (!out_stall) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && st_q != pbra_pkg::ST_OK) |-> addr_q == '0) else $error("addr on fail");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid) else $error("result dropped");
	a_free_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && isfree_q) |-> st_q != pbra_pkg::ST_NOSPC) else $error("free no space");
`endif

endmodule
`default_nettype wire

// File: tb/sv/page_bitmap_run_allocator_checker.sv
`default_nettype none
module page_bitmap_run_allocator_checker (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire  [14:0] cfg_wdata,
	input  wire         in_valid,
	input  wire         in_stall,
	input  wire         req_type,
	input  wire  [26:0] size_bytes,
	input  wire  [26:0] align_bytes,
	input  wire  [25:0] free_addr,
	input  wire         out_valid,
	input  wire         out_stall,
	input  wire  [1:0]  status,
	input  wire  [25:0] run_addr,
	output int          errors,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NPAGES   = 16384;
	localparam int PG_BITS  = 12;
	localparam int RESERVED = 4096;

	typedef struct {
		pbra_pkg::status_t st;
		logic [25:0]       addr;
	} alloc_result_t;

	// Shadow allocator state
	bit            shadow_busy [NPAGES];
	longint        last_end;
	longint        usable;
	alloc_result_t result_q[$];

	// First aligned run of cnt free pages in [from, limit)
	function automatic bit find_free_run(longint from, longint limit, longint cnt,
			longint a, output longint at);
		longint cand, p, stop;
		at = 0;
		cand = (from + a - 1) & ~(a - 1);
		while (cand + cnt <= limit) begin
			p = cand;
			stop = cand + cnt;
			while (p < stop && !shadow_busy[p])
				p++;
			if (p == stop) begin
				at = cand;
				return 1'b1;
			end
			cand = (p + 1 + a - 1) & ~(a - 1);
		end
		return 1'b0;
	endfunction

	// Apply one request to the shadow state and return its outcome
	function automatic alloc_result_t predict_request(logic rt, logic [26:0] sz,
			logic [26:0] al, logic [25:0] fa);
		alloc_result_t r;
		longint cnt, p, stop, ap, a, lim, lim2, at;
		bit ok;
		r.st = pbra_pkg::ST_OK;
		r.addr = '0;
		if (rt == pbra_pkg::REQ_FREE) begin
			cnt = longint'(sz) >> PG_BITS;
			p = longint'(fa) >> PG_BITS;
			if (cnt == 0) begin
				r.st = pbra_pkg::ST_ZERO;
				return r;
			end
			stop = p + cnt;
			if (stop > NPAGES)
				stop = NPAGES;
			for (; p < stop; p++)
				shadow_busy[p] = 1'b0;
			return r;
		end
		cnt = (longint'(sz) + (1 << PG_BITS) - 1) >> PG_BITS;
		if (cnt == 0) begin
			r.st = pbra_pkg::ST_ZERO;
			return r;
		end
		ap = longint'(al) >> PG_BITS;
		a = 1;
		while ((a << 1) <= ap)
			a = a << 1;
		lim = (usable > NPAGES) ? NPAGES : usable;
		lim2 = (last_end > lim) ? lim : last_end;
		ok = find_free_run(last_end + 1, lim, cnt, a, at);
		if (!ok)
			ok = find_free_run(0, lim2, cnt, a, at);
		if (!ok) begin
			r.st = pbra_pkg::ST_NOSPC;
			return r;
		end
		for (p = at; p < at + cnt; p++)
			shadow_busy[p] = 1'b1;
		last_end = at + cnt - 1;
		r.addr = 26'(at << PG_BITS);
		return r;
	endfunction

	// Track config, predict on input transactions, compare on output transactions
	always @(posedge clk or negedge arst_n) begin
		alloc_result_t e;
		if (!arst_n) begin
			for (int i = 0; i < NPAGES; i++)
				shadow_busy[i] = (i < RESERVED);
			last_end = (RESERVED == 0) ? NPAGES - 1 : RESERVED - 1;
			usable = 16384;
			result_q.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (cfg_we)
				usable = cfg_wdata;
			if (in_valid && !in_stall)
				result_q.push_back(predict_request(req_type, size_bytes, align_bytes,
					free_addr));
			if (out_valid && !out_stall) begin
				if (result_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result status=%0d run_addr=%h", $time,
						status, run_addr);
				end else begin
					e = result_q.pop_front();
					if (status !== e.st) begin
						errors++;
						$display("%0t: status expected %0d actual %0d", $time, e.st, status);
					end
					if (run_addr !== e.addr) begin
						errors++;
						$display("%0t: run_addr expected %h actual %h", $time, e.addr,
							run_addr);
					end
				end
			end
			pending = result_q.size();
		end
	end
endmodule
`default_nettype wire

// File: tb/sv/tb_page_bitmap_run_allocator.sv
`default_nettype none
module tb_page_bitmap_run_allocator;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int  PG        = 4096;
	localparam longint CYCLE_LIMIT = 6000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [14:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        req_type = pbra_pkg::REQ_ALLOC;
	logic [26:0] size_bytes = '0;
	logic [26:0] align_bytes = '0;
	logic [25:0] free_addr = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [25:0] run_addr;
	int          errors;
	int          pending;
	longint      cycles = 0;
	bit          hold_req = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	page_bitmap_run_allocator DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
		.size_bytes(size_bytes), .align_bytes(align_bytes), .free_addr(free_addr),
		.out_valid(out_valid), .out_stall(out_stall), .status(status),
		.run_addr(run_addr)
	);

	page_bitmap_run_allocator_checker u_chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
		.size_bytes(size_bytes), .align_bytes(align_bytes), .free_addr(free_addr),
		.out_valid(out_valid), .out_stall(out_stall), .status(status),
		.run_addr(run_addr), .errors(errors), .pending(pending)
	);

	// Mostly short gaps, a few long
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_page_bitmap_run_allocator: FAIL");
			$finish;
		end
	end

	// Result side: random stall, plus one long hold-off on request
	initial begin
		int quiet, n;
		quiet = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				for (n = 0; n < 1500; n++)
					@(negedge clk);
				hold_req = 1'b0;
			end else if (quiet > 0) begin
				out_stall <= 1'b0;
				quiet--;
			end else if ($urandom_range(0, 49) == 0) begin
				quiet = $urandom_range(20, 200);
				out_stall <= 1'b0;
			end else begin
				n = gap_len();
				if (n > 0) begin
					out_stall <= 1'b1;
					repeat (n - 1) @(negedge clk);
				end else begin
					out_stall <= 1'b0;
				end
			end
		end
	end

	// Offer one request and hold it until taken; inputs change at negedge
	task automatic send_request(logic rt, logic [26:0] sz, logic [26:0] al,
			logic [25:0] fa, bit no_gap = 1'b0);
		int g;
		g = no_gap ? 0 : gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		req_type <= rt;
		size_bytes <= sz;
		align_bytes <= al;
		free_addr <= fa;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	task automatic write_limit(logic [14:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Random request; hot pages kept low so searches stay short
	task automatic random_request(bit fast);
		int r;
		logic [26:0] sz, al;
		logic [25:0] fa;
		r = $urandom_range(0, 99);
		fa = 26'($urandom);
		al = 27'($urandom_range(0, 3) == 0 ? 0 : (PG << $urandom_range(0, 4)));
		if ($urandom_range(0, 9) == 0)
			al = 27'($urandom_range(0, 20000));
		if ($urandom_range(0, 49) == 0)
			al = 27'($urandom);
		if (r < 62) begin
			sz = 27'($urandom_range(1, 6 * PG));
			if ($urandom_range(0, 19) == 0)
				sz = '0;
			if ($urandom_range(0, 29) == 0)
				sz = 27'($urandom) | 27'h4000000;
			send_request(pbra_pkg::REQ_ALLOC, sz, al, fa, fast);
		end else begin
			sz = 27'($urandom_range(0, 6 * PG));
			fa = {14'($urandom_range(0, 70)), 12'($urandom)};
			if ($urandom_range(0, 19) == 0)
				fa = 26'($urandom);
			send_request(pbra_pkg::REQ_FREE, sz, al, fa, fast);
		end
	endtask

	task automatic random_phase(logic [14:0] lim, int n, bit pressure);
		write_limit(lim);
		for (int i = 0; i < n; i++) begin
			if (pressure && i == 50)
				hold_req = 1'b1;
			random_request(pressure && i >= 50 && i < 80);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: corners at the full limit, then at a limit of eight pages
		send_request(pbra_pkg::REQ_ALLOC, 27'd1, 27'd0, 26'd0);
		send_request(pbra_pkg::REQ_ALLOC, 27'd0, 27'd0, 26'h3FFFFFF);
		send_request(pbra_pkg::REQ_FREE, 27'd4095, 27'd0, 26'd0);
		send_request(pbra_pkg::REQ_FREE, 27'h4000000, 27'd0, 26'd0);
		send_request(pbra_pkg::REQ_ALLOC, 27'd4096, 27'd100, 26'd0);
		send_request(pbra_pkg::REQ_ALLOC, 27'd8193, 27'(3 * PG), 26'd0);
		send_request(pbra_pkg::REQ_ALLOC, 27'd4096, 27'h4000000, 26'd0);
		send_request(pbra_pkg::REQ_ALLOC, 27'h4000000, 27'd0, 26'd0);
		send_request(pbra_pkg::REQ_ALLOC, 27'h7FFFFFF, 27'h7FFFFFF, 26'd0);
		send_request(pbra_pkg::REQ_ALLOC, 27'(PG), 27'(8192 * PG), 26'd0);
		send_request(pbra_pkg::REQ_FREE, 27'(PG), 27'd0, 26'h3FFFFFF);
		send_request(pbra_pkg::REQ_ALLOC, 27'(3 * PG), 27'(2 * PG), 26'd0);
		send_request(pbra_pkg::REQ_FREE, 27'h7FFFFFF, 27'h7FFFFFF, 26'd0);
		write_limit(15'd8);
		send_request(pbra_pkg::REQ_ALLOC, 27'(4 * PG), 27'd0, 26'd0);
		send_request(pbra_pkg::REQ_ALLOC, 27'(4 * PG), 27'd0, 26'd0);
		send_request(pbra_pkg::REQ_ALLOC, 27'(PG), 27'd0, 26'd0);
		send_request(pbra_pkg::REQ_FREE, 27'(2 * PG), 27'd0, 26'(2 * PG));
		send_request(pbra_pkg::REQ_ALLOC, 27'(2 * PG), 27'd0, 26'd0);
		send_request(pbra_pkg::REQ_ALLOC, 27'(8 * PG), 27'd0, 26'd0);
		send_request(pbra_pkg::REQ_ALLOC, 27'(9 * PG), 27'd0, 26'd0);

		// Random phases over several limits
		random_phase(15'd64, 700, 1'b1);
		random_phase(15'd1, 60, 1'b0);
		random_phase(15'd0, 30, 1'b0);
		random_phase(15'h7FFF, 60, 1'b0);
		random_phase(15'd200, 300, 1'b0);
		random_phase(15'd16384, 100, 1'b0);
		random_phase(15'd64, 630, 1'b0);

		drain();
		if (errors == 0 && pending == 0) begin
			$display("tb_page_bitmap_run_allocator: PASS");
		end else begin
			$display("tb_page_bitmap_run_allocator: FAIL");
		end
		$finish;
	end
endmodule
`default_nettype wire
